>>> hw/rtl/lrc_pkg.sv
`default_nettype none

package lrc_pkg;

	// Width of one element and of each fetched word
	localparam int ELEM_BITS = 32;

	// Residual chunks: 2, 4, 8 and 16 bits, one for each bit of the line count
	localparam int CHUNK_COUNT = 4;
	localparam int BASE_BITS = 2;

	// Line count code of a block stored without compression
	localparam logic [3:0] LINE_CODE_RAW = 4'hf;

	typedef logic [CHUNK_COUNT-1:0][ELEM_BITS-1:0] chunk_words_t;

endpackage

`default_nettype wire

>>> hw/rtl/lrc_resid_extract.sv
`default_nettype none

module lrc_resid_extract (
	input  wire logic [3:0]                   line_count_code,
	input  wire logic [7:0]                   block_offset,
	input  wire lrc_pkg::chunk_words_t        chunk_words,
	input  wire logic [lrc_pkg::ELEM_BITS-1:0] raw_word,
	output logic      [lrc_pkg::ELEM_BITS-1:0] resid
);
	import lrc_pkg::*;

	logic [3:0] line_count;
	logic [CHUNK_COUNT-1:0][ELEM_BITS-1:0] part;

	// Line count is the code plus one; the raw code wraps to zero here and is
	// handled on its own below
	assign line_count = line_count_code + 4'd1;

	// Gather one field for each chunk present in the line count
	for (genvar k = 0; k < CHUNK_COUNT; k++) begin : g_chunk
		localparam int NB = BASE_BITS << k;
		localparam logic [3:0] LOW_MASK = 4'((1 << k) - 1);
		localparam logic [3:0] OWN_BIT = 4'(1 << k);

		logic [4:0]    sel_shift;
		logic [3:0]    lower_bits;
		logic [NB-1:0] field;
		logic          top_chunk;
		logic [ELEM_BITS-1:0] field_ext;

		always_comb begin
			// Sub-slot is the offset divided by 16 << k; the field starts at sub-slot times its width
			sel_shift  = 5'(block_offset >> (4 + k)) << (k + 1);
			field      = chunk_words[k][sel_shift +: NB];
			top_chunk  = (line_count & ~LOW_MASK) == OWN_BIT;
			lower_bits = 4'(5'(line_count & LOW_MASK) << 1);
			field_ext  = ELEM_BITS'(field);
			// Sign-extend the highest chunk only
			if (top_chunk && field[NB-1]) begin
				field_ext = field_ext | ~ELEM_BITS'({NB{1'b1}});
			end
			if (line_count[k]) begin
				part[k] = field_ext << lower_bits;
			end else begin
				part[k] = '0;
			end
		end
	end

	// Merge the fields, or pass the raw word for an uncompressed block
	always_comb begin
		resid = '0;
		if (line_count_code == LINE_CODE_RAW) begin
			resid = raw_word;
		end else begin
			for (int i = 0; i < CHUNK_COUNT; i++) begin
				resid = resid | part[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lrc_element_decode.sv
`default_nettype none

// Channel   Handshake             Word
// input     in_valid / in_stall   position, line count, parameters, residual words
// output    out_valid / out_stall element_value
//
// Three register stages: field gather and parameter scaling, slope times
// position, final add. One word enters per cycle unless in_stall is high.
// Reset clears only the stage valid bits; the payload registers are not reset.
// A stall on the output holds the last stage; earlier stages keep filling any
// empty slot, so in_stall rises only when all three stages hold a word.

module lrc_element_decode #(
	parameter int WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [8:0]  position_in_pair,
	input  wire logic [3:0]  line_count_code,
	input  wire logic [31:0] intercept_code,
	input  wire logic [15:0] slope_code,
	input  wire logic [1:0]  intercept_shift,
	input  wire logic [1:0]  slope_shift,
	input  wire logic [31:0] word_two_bit,
	input  wire logic [31:0] word_four_bit,
	input  wire logic [31:0] word_eight_bit,
	input  wire logic [31:0] word_sixteen_bit,
	input  wire logic [31:0] raw_word,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      element_value
);
	import lrc_pkg::*;

	chunk_words_t         chunk_words;
	logic [ELEM_BITS-1:0] resid;
	logic [WORD_BITS-1:0] icpt_ext;
	logic [WORD_BITS-1:0] slope_ext;

	logic adv_s1, adv_s2, adv_s3;
	logic v_s1, v_s2, v_s3;

	logic [WORD_BITS-1:0] icpt_s1, slope_s1;
	logic [8:0]           pos_s1;
	logic [ELEM_BITS-1:0] resid_s1;

	logic [WORD_BITS-1:0] icpt_s2, prod_s2;
	logic [ELEM_BITS-1:0] resid_s2;

	logic [ELEM_BITS-1:0] sum_s3;

	// Advance a stage when it is empty or the next one advances
	assign adv_s3   = !v_s3 || !out_stall;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	assign chunk_words[0] = word_two_bit;
	assign chunk_words[1] = word_four_bit;
	assign chunk_words[2] = word_eight_bit;
	assign chunk_words[3] = word_sixteen_bit;

	lrc_resid_extract u_resid (
		.line_count_code (line_count_code),
		.block_offset    (position_in_pair[7:0]),
		.chunk_words     (chunk_words),
		.raw_word        (raw_word),
		.resid           (resid)
	);

	// Sign-extend both parameters to the datapath width
	assign icpt_ext  = WORD_BITS'(signed'(intercept_code));
	assign slope_ext = WORD_BITS'(signed'(slope_code));

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 1: scale parameters, hold the gathered residual
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			icpt_s1  <= icpt_ext << {intercept_shift, 3'b000};
			slope_s1 <= slope_ext << {slope_shift, 3'b000};
			pos_s1   <= position_in_pair;
			resid_s1 <= resid;
		end
	end

	// Stage 2: slope times position, wrapping
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			prod_s2  <= slope_s1 * WORD_BITS'(pos_s1);
			icpt_s2  <= icpt_s1;
			resid_s2 <= resid_s1;
		end
	end

	// Stage 3: prediction plus residual, keep the low element bits
	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			sum_s3 <= ELEM_BITS'(icpt_s2 + prod_s2 + WORD_BITS'(resid_s2));
		end
	end

	assign out_valid     = v_s3;
	assign element_value = sum_s3;

`ifndef NO_ASSERTIONS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_stall))
		else $error("input stalled with an empty stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted word missing from stage 1");

	a_s2_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && adv_s3) |=> v_s3)
		else $error("word lost between stage 2 and stage 3");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> (v_s1 && $stable(icpt_s1) && $stable(resid_s1)))
		else $error("stage 1 word changed while blocked");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;

	import lrc_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int NUM_DIRECTED = 24;
	localparam int RANDOM_PER_PHASE = 255;
	localparam logic [31:0] ONES = 32'hffffffff;
	localparam logic [31:0] MIX_A = 32'h9e3779b9;
	localparam logic [31:0] MIX_B = 32'h6a09e667;
	localparam logic [31:0] MIX_C = 32'hbb67ae85;
	localparam logic [31:0] MIX_D = 32'h3c6ef372;

	// One input word of the decoder
	typedef struct packed {
		logic [8:0]  position_in_pair;
		logic [3:0]  line_count_code;
		logic [31:0] intercept_code;
		logic [15:0] slope_code;
		logic [1:0]  intercept_shift;
		logic [1:0]  slope_shift;
		logic [31:0] word_two_bit;
		logic [31:0] word_four_bit;
		logic [31:0] word_eight_bit;
		logic [31:0] word_sixteen_bit;
		logic [31:0] raw_word;
	} element_word_t;

	// Directed row: the word and, where obvious, its element typed in by hand
	typedef struct packed {
		element_word_t word;
		logic          by_hand;
		logic [31:0]   value;
	} element_row_t;

	localparam element_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		// all zero, smallest line count
		'{'{9'd0, 4'd0, 32'h0, 16'h0, 2'd0, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
			1'b1, 32'h0},
		// lone 2-bit field of ones sign-extends, odd block
		'{'{9'd256, 4'd0, 32'h0, 16'h0, 2'd0, 2'd0, 32'h3, ONES, ONES, ONES, ONES},
			1'b1, ONES},
		// absent chunk words and other sub-slots ignored
		'{'{9'd0, 4'd0, 32'h0, 16'h0, 2'd0, 2'd0, 32'hfffffffc, ONES, ONES, ONES, ONES},
			1'b1, 32'h0},
		// uncompressed block takes the raw word only
		'{'{9'd37, LINE_CODE_RAW, 32'h0, 16'h0, 2'd0, 2'd0, ONES, ONES, ONES, ONES,
			32'hdeadbeef}, 1'b1, 32'hdeadbeef},
		'{'{9'd0, LINE_CODE_RAW, ONES, 16'h0, 2'd0, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h1}, 1'b1, 32'h0},
		// largest intercept scale
		'{'{9'd0, LINE_CODE_RAW, 32'h1, 16'h0, 2'd3, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0}, 1'b1, 32'h01000000},
		// negative slope at the last position
		'{'{9'd511, LINE_CODE_RAW, 32'h0, 16'hffff, 2'd0, 2'd0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0}, 1'b1, 32'hfffffe01},
		'{'{9'd1, LINE_CODE_RAW, 32'h0, 16'h8000, 2'd0, 2'd1, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0}, 1'b1, 32'hff800000},
		'{'{9'd511, LINE_CODE_RAW, 32'h7fffffff, 16'h7fff, 2'd3, 2'd3, ONES, ONES, ONES,
			ONES, ONES}, 1'b0, 32'h0},
		// every compressed line count, assorted positions
		'{'{9'd255, 4'd0, MIX_A, 16'h1234, 2'd1, 2'd0, MIX_A, MIX_B, MIX_C, MIX_D,
			ONES}, 1'b0, 32'h0},
		'{'{9'd255, 4'd1, MIX_B, 16'hfedc, 2'd0, 2'd1, ONES, ONES, ONES, ONES, ONES},
			1'b0, 32'h0},
		'{'{9'd256, 4'd2, MIX_C, 16'h0001, 2'd2, 2'd2, MIX_B, MIX_C, MIX_D, MIX_A,
			ONES}, 1'b0, 32'h0},
		'{'{9'd192, 4'd3, MIX_D, 16'h8001, 2'd3, 2'd0, MIX_C, MIX_D, MIX_A, MIX_B,
			ONES}, 1'b0, 32'h0},
		'{'{9'd300, 4'd4, 32'h80000000, 16'h7fff, 2'd0, 2'd3, MIX_D, MIX_A, MIX_B,
			MIX_C, ONES}, 1'b0, 32'h0},
		'{'{9'd127, 4'd5, MIX_A, 16'h00ff, 2'd1, 2'd1, ONES, ONES, ONES, ONES, 32'h0},
			1'b0, 32'h0},
		'{'{9'd64, 4'd6, MIX_B, 16'hff00, 2'd2, 2'd3, MIX_A, MIX_B, MIX_C, MIX_D,
			32'h0}, 1'b0, 32'h0},
		'{'{9'd128, 4'd7, 32'h0, 16'h0, 2'd0, 2'd0, MIX_B, MIX_C, MIX_D, 32'hffff0000,
			ONES}, 1'b0, 32'h0},
		'{'{9'd383, 4'd8, MIX_C, 16'h5555, 2'd3, 2'd2, MIX_C, MIX_D, MIX_A, MIX_B,
			ONES}, 1'b0, 32'h0},
		'{'{9'd31, 4'd9, MIX_D, 16'haaaa, 2'd2, 2'd1, ONES, ONES, ONES, ONES, ONES},
			1'b0, 32'h0},
		'{'{9'd480, 4'd10, ONES, 16'hffff, 2'd1, 2'd3, MIX_D, MIX_A, MIX_B, MIX_C,
			32'h0}, 1'b0, 32'h0},
		'{'{9'd200, 4'd11, MIX_A, 16'h8000, 2'd0, 2'd2, MIX_A, MIX_B, MIX_C, MIX_D,
			ONES}, 1'b0, 32'h0},
		'{'{9'd15, 4'd12, MIX_B, 16'h7fff, 2'd3, 2'd1, MIX_B, MIX_C, MIX_D, MIX_A,
			ONES}, 1'b0, 32'h0},
		'{'{9'd448, 4'd13, MIX_C, 16'h0f0f, 2'd1, 2'd0, ONES, ONES, ONES, ONES, 32'h0},
			1'b0, 32'h0},
		'{'{9'd511, 4'd14, MIX_D, 16'hf0f0, 2'd2, 2'd2, ONES, ONES, ONES, ONES, 32'h0},
			1'b0, 32'h0}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic out_valid;
	logic out_stall;
	logic [31:0] element_value;
	element_word_t offered_word;

	logic [31:0] expected_elements [$];
	int mismatch_count;
	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	int hold_serial;
	int hold_served;

	lrc_element_decode i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.position_in_pair (offered_word.position_in_pair),
		.line_count_code  (offered_word.line_count_code),
		.intercept_code   (offered_word.intercept_code),
		.slope_code       (offered_word.slope_code),
		.intercept_shift  (offered_word.intercept_shift),
		.slope_shift      (offered_word.slope_shift),
		.word_two_bit     (offered_word.word_two_bit),
		.word_four_bit    (offered_word.word_four_bit),
		.word_eight_bit   (offered_word.word_eight_bit),
		.word_sixteen_bit (offered_word.word_sixteen_bit),
		.raw_word         (offered_word.raw_word),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.element_value    (element_value)
	);

	// Rebuild the element: scaled linear prediction plus gathered residual
	function automatic logic [31:0] rebuild_element(input element_word_t w);
		chunk_words_t chunk_words;
		logic [31:0] intercept;
		logic [31:0] slope;
		logic [31:0] residual;
		logic [63:0] field;
		logic [63:0] sign_bit;
		int lines;
		int offset;
		int nbits;
		int sub_slot;
		int lower_bits;
		int k;
		chunk_words = {w.word_sixteen_bit, w.word_eight_bit, w.word_four_bit,
			w.word_two_bit};
		lines = int'(w.line_count_code) + 1;
		offset = int'(w.position_in_pair[7:0]);
		intercept = w.intercept_code << (8 * w.intercept_shift);
		slope = {{16{w.slope_code[15]}}, w.slope_code} << (8 * w.slope_shift);
		residual = '0;
		if (w.line_count_code == LINE_CODE_RAW) begin
			residual = w.raw_word;
		end else begin
			for (k = 0; k < CHUNK_COUNT; k++) begin
				if (((lines >> k) & 1) == 1) begin
					nbits = BASE_BITS << k;
					sub_slot = offset / (16 << k);
					lower_bits = BASE_BITS * (lines & ((1 << k) - 1));
					field = ({32'h0, chunk_words[k]} >> (nbits * sub_slot))
						& ((64'd1 << nbits) - 64'd1);
					// highest chunk carries the sign
					if ((lines >> k) == 1) begin
						sign_bit = 64'd1 << (nbits - 1);
						field = (field ^ sign_bit) - sign_bit;
					end
					residual = residual | 32'(field << lower_bits);
				end
			end
		end
		return intercept + slope * {23'h0, w.position_in_pair} + residual;
	endfunction

	// Mostly random words, with all-zero and all-one words mixed in
	function automatic logic [31:0] pick_word();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? ONES : 32'h0;
		return $urandom;
	endfunction

	function automatic element_word_t draw_element();
		element_word_t w;
		w.position_in_pair = 9'($urandom_range(511));
		w.line_count_code = 4'($urandom_range(15));
		w.intercept_code = pick_word();
		w.slope_code = 16'(pick_word());
		w.intercept_shift = 2'($urandom_range(3));
		w.slope_shift = 2'($urandom_range(3));
		w.word_two_bit = pick_word();
		w.word_four_bit = pick_word();
		w.word_eight_bit = pick_word();
		w.word_sixteen_bit = pick_word();
		w.raw_word = pick_word();
		return w;
	endfunction

	// Offer one word, starting and ending at a falling edge
	task automatic offer_element(input element_word_t w, input logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		offered_word <= w;
		do @(posedge clk); while (in_stall);
		expected_elements.push_back(value);
		@(negedge clk);
	endtask

	// Drop valid and hold until every pending element is out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_elements.size() != 0)
			@(negedge clk);
	endtask

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Receiver: random stalls, or a long hold when one is requested
	initial begin : receiver
		int held;
		held = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_serial != hold_served) begin
				out_stall <= 1'b1;
				held++;
				if (held >= hold_cycles) begin
					hold_served = hold_serial;
					held = 0;
				end
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Compare each element leaving the block with the oldest prediction
	always @(posedge clk) begin : check_elements
		logic [31:0] wanted;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_elements.size() == 0) begin
				$error("element_value: expected none, actual %h", element_value);
				mismatch_count++;
			end else begin
				wanted = expected_elements.pop_front();
				if (element_value !== wanted) begin
					$error("element_value: expected %h, actual %h", wanted, element_value);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		element_word_t w;
		int n;
		int phase;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		offered_word = '0;
		mismatch_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		hold_serial = 0;
		hold_served = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (n = 0; n < NUM_DIRECTED; n++) begin
			w = DIRECTED_ROWS[n].word;
			offer_element(w, DIRECTED_ROWS[n].by_hand ? DIRECTED_ROWS[n].value
				: rebuild_element(w));
		end
		wait_for_results();

		// long output hold while the sender keeps offering, to fill the pipe
		hold_cycles = 150;
		hold_serial++;
		for (n = 0; n < 12; n++) begin
			w = draw_element();
			offer_element(w, rebuild_element(w));
		end
		wait_for_results();

		// random words under each idling mix
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 62; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 62; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				w = draw_element();
				offer_element(w, rebuild_element(w));
			end
			wait_for_results();
		end

		// allow for stray words past the pipeline depth
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

>>> lrc_element_decode.f
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_resid_extract.sv
hw/rtl/lrc_element_decode.sv
verif/tb.sv
